// ----- hdl/gsh_pkg.sv -----
// Package for the Gimli sponge hash block: state type, permutation constants
// and the message and digest constants used by the sequencer and the round unit.
// No dependencies.
package gsh_pkg;

    // Twelve 32-bit words of permutation state.
    typedef logic [31:0]           t_word;
    typedef logic [11:0][31:0]     t_state;

    // Round counter runs from ROUNDS down to one.
    typedef logic [4:0]            t_round;

    localparam t_round     ROUNDS        = 5'd24;
    localparam t_word      ROUND_CONST   = 32'h9e37_7900;
    localparam logic [3:0] LAST_OFFSET   = 4'd15;
    localparam logic [7:0] PAD_BYTE      = 8'h01;
    localparam logic [7:0] DOMAIN_BYTE   = 8'h01;
    localparam logic [6:0] MAX_OUT_BYTES = 7'd64;
    localparam logic [6:0] OUT_LEN_RESET = 7'd32;

endpackage

// ----- hdl/gsh_if.sv -----
// Valid/ready channels of the Gimli sponge hash block: message input and
// digest output. No dependencies.
interface gsh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    output ready);
endinterface

interface gsh_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- hdl/gsh_round.sv -----
// One round of the Gimli permutation: column SP-box on all four columns,
// then the swap and round constant selected by the round number.
// Depends on gsh_pkg.
module gsh_round
    import gsh_pkg::*;
(
    input  t_state i_state,
    input  t_round i_round,
    output t_state o_state
);

    t_state w_sp;

    // Nonlinear layer, one column at a time.
    always_comb begin
        t_word x, y, z;
        w_sp = i_state;
        for (int c = 0; c < 4; c++) begin
            x = {i_state[c][7:0], i_state[c][31:8]};
            y = {i_state[4 + c][22:0], i_state[4 + c][31:23]};
            z = i_state[8 + c];
            w_sp[8 + c] = x ^ (z << 1) ^ ((y & z) << 2);
            w_sp[4 + c] = y ^ x ^ ((x | z) << 1);
            w_sp[c]     = z ^ y ^ ((x & y) << 3);
        end
    end

    // Linear layer: small swap with constant every fourth round, big swap
    // two rounds later.
    always_comb begin
        o_state = w_sp;
        unique case (i_round[1:0])
            2'd0: begin
                o_state[0] = w_sp[1] ^ ROUND_CONST ^ {27'd0, i_round};
                o_state[1] = w_sp[0];
                o_state[2] = w_sp[3];
                o_state[3] = w_sp[2];
            end
            2'd2: begin
                o_state[0] = w_sp[2];
                o_state[1] = w_sp[3];
                o_state[2] = w_sp[0];
                o_state[3] = w_sp[1];
            end
            default: begin
                o_state = w_sp;
            end
        endcase
    end

endmodule

// ----- hdl/gimli_sponge_hash.sv -----
// Top level of the Gimli sponge hash block: sequencer, state register and
// byte access. Depends on gsh_pkg, gsh_if and gsh_round.
//
// Gimli-Hash with extendable output, one message byte per request. A request
// carrying a byte is absorbed as it is accepted; when it fills a 16-byte block
// the 24-round permutation follows, one round per cycle through a single
// shared round unit. A request marked last goes through the padding state,
// then for every 16 digest bytes a permutation, and each digest byte is held
// on the output until it is taken. The digest length comes from the out_len
// register (reset 32); zero is treated as 1 and values above 64 as 64. After
// the final digest byte the state clears for the next message. The input is
// not ready while a request is being worked on.
module gimli_sponge_hash
    import gsh_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [6:0]     i_cfg_wdata,
    gsh_in_if.sink         i_in,
    gsh_out_if.source      o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PAD  = 2'd1;
    localparam logic [1:0] S_PERM = 2'd2;
    localparam logic [1:0] S_SQZ  = 2'd3;

    logic [1:0] r_state, n_state;
    t_state     r_st, n_st;
    t_round     r_rnd, n_rnd;
    logic [3:0] r_off, n_off;
    logic       r_fin, n_fin;
    logic       r_sq, n_sq;
    logic [5:0] r_cnt, n_cnt;
    logic [6:0] r_n, n_n;
    logic [6:0] r_out_len;

    t_state     w_round_out;
    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_final;
    logic [3:0] w_word;
    logic [4:0] w_bit;

    gsh_round u_round (
        .i_state (r_st),
        .i_round (r_rnd),
        .o_state (w_round_out)
    );

    // Byte pointer into the rate part of the state.
    assign w_word = {2'b00, r_off[3:2]};
    assign w_bit  = {r_off[1:0], 3'b000};

    // Handshakes and digest output, read straight from the state.
    assign i_in.ready     = (r_state == S_IDLE);
    assign w_in_acc       = i_in.valid && i_in.ready;
    assign o_out.valid    = (r_state == S_SQZ);
    assign w_out_acc      = o_out.valid && o_out.ready;
    assign w_final        = ({1'b0, r_cnt} + 7'd1) == r_n;
    assign o_out.out_byte = r_st[w_word][w_bit +: 8];
    assign o_out.out_last = w_final;

    // Sequencer next-state logic.
    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        n_rnd   = r_rnd;
        n_off   = r_off;
        n_fin   = r_fin;
        n_sq    = r_sq;
        n_cnt   = r_cnt;
        n_n     = r_n;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_fin = i_in.last;
                    n_sq  = 1'b0;
                    if (i_in.has_byte) begin
                        n_st[w_word][w_bit +: 8] = r_st[w_word][w_bit +: 8] ^ i_in.data_byte;
                        if (r_off == LAST_OFFSET) begin
                            n_off   = 4'd0;
                            n_rnd   = ROUNDS;
                            n_state = S_PERM;
                        end else begin
                            n_off = r_off + 4'd1;
                            if (i_in.last) begin
                                n_state = S_PAD;
                            end
                        end
                    end else if (i_in.last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                n_st[w_word][w_bit +: 8] = r_st[w_word][w_bit +: 8] ^ PAD_BYTE;
                n_st[11][31:24] = n_st[11][31:24] ^ DOMAIN_BYTE;
                priority if (r_out_len == 7'd0) begin
                    n_n = 7'd1;
                end else if (r_out_len > MAX_OUT_BYTES) begin
                    n_n = MAX_OUT_BYTES;
                end else begin
                    n_n = r_out_len;
                end
                n_cnt   = 6'd0;
                n_sq    = 1'b1;
                n_rnd   = ROUNDS;
                n_state = S_PERM;
            end
            S_PERM: begin
                n_st  = w_round_out;
                n_rnd = r_rnd - 5'd1;
                if (r_rnd == 5'd1) begin
                    n_off = 4'd0;
                    priority if (r_sq) begin
                        n_state = S_SQZ;
                    end else if (r_fin) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SQZ: begin
                if (w_out_acc) begin
                    if (w_final) begin
                        n_st    = '0;
                        n_off   = 4'd0;
                        n_sq    = 1'b0;
                        n_fin   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 6'd1;
                        if (r_off == LAST_OFFSET) begin
                            n_off   = 4'd0;
                            n_rnd   = ROUNDS;
                            n_state = S_PERM;
                        end else begin
                            n_off = r_off + 4'd1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= '0;
            r_rnd   <= ROUNDS;
            r_off   <= 4'd0;
            r_fin   <= 1'b0;
            r_sq    <= 1'b0;
            r_cnt   <= 6'd0;
            r_n     <= 7'd1;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
            r_rnd   <= n_rnd;
            r_off   <= n_off;
            r_fin   <= n_fin;
            r_sq    <= n_sq;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
        end
    end

    // Digest length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_len <= OUT_LEN_RESET;
        end else if (i_cfg_we) begin
            r_out_len <= i_cfg_wdata;
        end
    end

    // The round counter stays within the permutation while it runs.
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PERM) |-> (r_rnd >= 5'd1 && r_rnd <= ROUNDS))
        else $error("round counter out of range during permutation");

    // Every permutation leaves the byte pointer at the start of a block.
    a_perm_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PERM && r_rnd == 5'd1) |=> (r_off == 4'd0))
        else $error("byte pointer not cleared after permutation");

    // The digest byte count never reaches the requested length while squeezing.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQZ) |-> ({1'b0, r_cnt} < r_n && r_n <= MAX_OUT_BYTES))
        else $error("digest byte count beyond length");

    // The final digest byte leaves a cleared state and an idle block.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_final) |=> (r_state == S_IDLE && r_st == '0 && r_off == 4'd0))
        else $error("state not cleared after final digest byte");

endmodule
